@@ design/mtm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mtm_pkg;

    // Widths of the word fields.
    localparam int NODE_W  = 17;
    localparam int VALUE_W = 17;
    localparam int MEX_W   = 18;

    // Wide enough for any index or count up to the largest supported depth.
    localparam int WIDE_W = 21;

    // Entering values are limited to this before they are counted.
    localparam int VALUE_CAP = 100000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_NODE_RD,
        ST_REF_RD,
        ST_BLK_ADR,
        ST_BLK_RD,
        ST_SCAN_B,
        ST_SCAN_V,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

@@ design/mex_tracking_multiset_core.sv @@
// Multiset of values with a smallest-absent-value (mex) query.
// Input channel (s_valid/s_ready, s_node, s_value): each word toggles one
// node in or out of the set. A node that enters stores its value, limited
// to the top value, and raises that value's count; a node that leaves uses
// its stored value. A node index of NODE_COUNT or more changes nothing.
// Result channel (m_valid/m_ready, m_mex, m_now_present): one word for
// every input word, in order.
// One word is handled at a time. The update runs through the states
// NODE_RD, REF_RD, BLK_ADR and BLK_RD in read-modify-write on the node,
// count and block memories; the mex search then reads one block count per
// cycle until it meets a block that is not full, and one value count per
// cycle inside that block. How long a word takes is set by how far the
// search runs, since each memory has a single read port.
// After reset a clearing pass zeroes every address of the memories, with
// s_ready low. A stalled result waits in the output register; s_ready
// rises again once the result has been loaded there, so the next word is
// taken while the receiver still holds off.
`timescale 1ns / 1ps
`default_nettype none

module mex_tracking_multiset_core
    import mtm_pkg::*;
#(
    parameter int NODE_COUNT  = 131072,
    parameter int VALUE_COUNT = 131072,
    parameter int BLOCK_SIZE  = 512
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [NODE_W-1:0]  s_node,
    input  wire logic [VALUE_W-1:0] s_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [MEX_W-1:0]        m_mex,
    output logic                    m_now_present
);

    localparam int NODE_AW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int VAL_AW    = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
    localparam int NUM_BLK   = (VALUE_COUNT + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BLK_AW    = (NUM_BLK > 1) ? $clog2(NUM_BLK) : 1;
    localparam int LAST_SPAN = VALUE_COUNT - (NUM_BLK - 1) * BLOCK_SIZE;
    localparam int REF_W     = $clog2(NODE_COUNT + 1);
    localparam int CNT_W     = $clog2(BLOCK_SIZE + 1);
    localparam int VB_W      = VAL_AW + 1;
    localparam int TOP_VAL   = (VALUE_CAP < VALUE_COUNT - 1) ? VALUE_CAP : VALUE_COUNT - 1;
    localparam int CLR_LEN   = (NODE_COUNT > VALUE_COUNT) ? NODE_COUNT : VALUE_COUNT;
    localparam int CLR_W     = $clog2(CLR_LEN) + 1;

    // Block index by multiplication with a rounded-up reciprocal; exact for
    // every value below 2**VAL_AW.
    localparam int DIV_L = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 0;
    localparam int DIV_S = VAL_AW + DIV_L;
    localparam int M_W   = VAL_AW + 1;
    localparam int P_W   = 2 * VAL_AW + 2;
    localparam longint unsigned DIV_M_L =
        ((64'd1 << DIV_S) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE);
    localparam logic [M_W-1:0] DIV_M = M_W'(DIV_M_L);

    // Memories. A node entry holds the membership bit above the stored value.
    logic [VAL_AW:0]  node_mem [NODE_COUNT];
    logic [REF_W-1:0] ref_mem  [VALUE_COUNT];
    logic [CNT_W-1:0] blk_mem  [NUM_BLK];

    logic               node_we;
    logic [NODE_AW-1:0] node_wa;
    logic [VAL_AW:0]    node_wd;
    logic [NODE_AW-1:0] node_ra;
    logic [VAL_AW:0]    node_q;

    logic              ref_we;
    logic [VAL_AW-1:0] ref_wa;
    logic [REF_W-1:0]  ref_wd;
    logic [VAL_AW-1:0] ref_ra;
    logic [REF_W-1:0]  ref_q;

    logic              blk_we;
    logic [BLK_AW-1:0] blk_wa;
    logic [CNT_W-1:0]  blk_wd;
    logic [BLK_AW-1:0] blk_ra;
    logic [CNT_W-1:0]  blk_q;

    state_t state_reg, state_next;

    logic [CLR_W-1:0]   clr_reg, clr_next;
    logic [NODE_AW-1:0] node_reg, node_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               enter_reg, enter_next;
    logic [VAL_AW-1:0]  v_reg, v_next;
    logic               bump_reg, bump_next;
    logic               drop_reg, drop_next;
    logic [P_W-1:0]     prod_reg, prod_next;
    logic [BLK_AW-1:0]  blkidx_reg, blkidx_next;

    logic [BLK_AW:0]    bi_reg, bi_next;
    logic [BLK_AW-1:0]  bchk_reg, bchk_next;
    logic               bpend_reg, bpend_next;
    logic [VB_W-1:0]    vbase_reg, vbase_next;
    logic [VB_W-1:0]    vi_reg, vi_next;
    logic [VB_W-1:0]    vend_reg, vend_next;
    logic [VB_W-1:0]    vchk_reg, vchk_next;
    logic               vpend_reg, vpend_next;
    logic [VB_W-1:0]    mexv_reg, mexv_next;

    logic               m_valid_reg, m_valid_next;
    logic [MEX_W-1:0]   m_mex_reg, m_mex_next;
    logic               m_pres_reg, m_pres_next;

    logic [WIDE_W-1:0] node_wide;
    logic [WIDE_W-1:0] value_wide;
    logic              node_in_range;
    logic              accept;
    logic              out_free;
    logic              clr_last;
    logic [VAL_AW-1:0] clamped;
    logic [VAL_AW-1:0] v_cur;
    logic [CNT_W-1:0]  cur_span;
    logic              blk_found;
    logic              blk_done;
    logic              val_found;
    logic              val_done;

    assign node_wide     = WIDE_W'(s_node);
    assign node_in_range = node_wide < WIDE_W'(NODE_COUNT);
    assign value_wide    = WIDE_W'(value_reg);
    assign clamped       = (value_wide > WIDE_W'(TOP_VAL)) ? VAL_AW'(TOP_VAL)
                                                           : value_wide[VAL_AW-1:0];
    assign v_cur         = node_q[VAL_AW] ? node_q[VAL_AW-1:0] : clamped;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign clr_last = clr_reg == CLR_W'(CLR_LEN - 1);

    // The last block may hold fewer values than the others.
    assign cur_span  = (bchk_reg == BLK_AW'(NUM_BLK - 1)) ? CNT_W'(LAST_SPAN)
                                                          : CNT_W'(BLOCK_SIZE);
    assign blk_found = bpend_reg && (blk_q != cur_span);
    assign blk_done  = !blk_found && (bi_reg == (BLK_AW + 1)'(NUM_BLK));
    assign val_found = vpend_reg && (ref_q == '0);
    assign val_done  = !val_found && (vi_reg == vend_reg);

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_mem[node_wa] <= node_wd;
        end
        node_q <= node_mem[node_ra];
    end

    always_ff @(posedge aclk) begin
        if (ref_we) begin
            ref_mem[ref_wa] <= ref_wd;
        end
        ref_q <= ref_mem[ref_ra];
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_wa] <= blk_wd;
        end
        blk_q <= blk_mem[blk_ra];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = node_in_range ? ST_NODE_RD : ST_SCAN_B;
                end
            end
            ST_NODE_RD: state_next = ST_REF_RD;
            ST_REF_RD:  state_next = ST_BLK_ADR;
            ST_BLK_ADR: state_next = ST_BLK_RD;
            ST_BLK_RD:  state_next = ST_SCAN_B;
            ST_SCAN_B: begin
                if (blk_found) begin
                    state_next = ST_SCAN_V;
                end else if (blk_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_SCAN_V: begin
                if (val_found || val_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        s_ready      = 1'b0;
        clr_next     = clr_reg;
        node_next    = node_reg;
        value_next   = value_reg;
        enter_next   = enter_reg;
        v_next       = v_reg;
        bump_next    = bump_reg;
        drop_next    = drop_reg;
        prod_next    = prod_reg;
        blkidx_next  = blkidx_reg;
        bi_next      = bi_reg;
        bchk_next    = bchk_reg;
        bpend_next   = bpend_reg;
        vbase_next   = vbase_reg;
        vi_next      = vi_reg;
        vend_next    = vend_reg;
        vchk_next    = vchk_reg;
        vpend_next   = vpend_reg;
        mexv_next    = mexv_reg;
        m_mex_next   = m_mex_reg;
        m_pres_next  = m_pres_reg;
        m_valid_next = m_ready ? 1'b0 : m_valid_reg;

        node_we = 1'b0;
        node_wa = node_reg;
        node_wd = enter_reg ? {1'b1, clamped} : {1'b0, node_q[VAL_AW-1:0]};
        node_ra = node_wide[NODE_AW-1:0];

        ref_we = 1'b0;
        ref_wa = v_reg;
        ref_wd = ref_q;
        ref_ra = (state_reg == ST_NODE_RD) ? v_cur : vi_reg[VAL_AW-1:0];

        blk_we = 1'b0;
        blk_wa = blkidx_reg;
        blk_wd = blk_q;
        blk_ra = (state_reg == ST_BLK_ADR) ? prod_reg[DIV_S +: BLK_AW]
                                           : bi_reg[BLK_AW-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                node_we  = clr_reg < CLR_W'(NODE_COUNT);
                node_wa  = clr_reg[NODE_AW-1:0];
                node_wd  = '0;
                ref_we   = clr_reg < CLR_W'(VALUE_COUNT);
                ref_wa   = clr_reg[VAL_AW-1:0];
                ref_wd   = '0;
                blk_we   = clr_reg < CLR_W'(NUM_BLK);
                blk_wa   = clr_reg[BLK_AW-1:0];
                blk_wd   = '0;
                clr_next = clr_reg + CLR_W'(1);
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    node_next  = node_wide[NODE_AW-1:0];
                    value_next = s_value;
                    enter_next = 1'b0;
                    bi_next    = '0;
                    bpend_next = 1'b0;
                    vbase_next = '0;
                end
            end
            ST_NODE_RD: begin
                enter_next = !node_q[VAL_AW];
                v_next     = v_cur;
                node_we    = 1'b1;
                node_wd    = node_q[VAL_AW] ? {1'b0, node_q[VAL_AW-1:0]}
                                            : {1'b1, clamped};
            end
            ST_REF_RD: begin
                ref_we    = 1'b1;
                bump_next = enter_reg && (ref_q == '0);
                drop_next = !enter_reg && (ref_q == REF_W'(1));
                if (enter_reg) begin
                    if (ref_q != '1) begin
                        ref_wd = ref_q + REF_W'(1);
                    end
                end else if (ref_q != '0) begin
                    ref_wd = ref_q - REF_W'(1);
                end
                prod_next = P_W'(v_reg) * P_W'(DIV_M);
            end
            ST_BLK_ADR: begin
                blkidx_next = prod_reg[DIV_S +: BLK_AW];
            end
            ST_BLK_RD: begin
                if (bump_reg) begin
                    blk_we = 1'b1;
                    blk_wd = blk_q + CNT_W'(1);
                end else if (drop_reg && (blk_q != '0)) begin
                    blk_we = 1'b1;
                    blk_wd = blk_q - CNT_W'(1);
                end
            end
            ST_SCAN_B: begin
                if (blk_found) begin
                    vi_next    = vbase_reg;
                    vend_next  = vbase_reg + VB_W'(cur_span);
                    vpend_next = 1'b0;
                end else begin
                    if (bpend_reg) begin
                        vbase_next = vbase_reg + VB_W'(BLOCK_SIZE);
                    end
                    if (blk_done) begin
                        mexv_next = VB_W'(VALUE_COUNT);
                    end else begin
                        bchk_next  = bi_reg[BLK_AW-1:0];
                        bpend_next = 1'b1;
                        bi_next    = bi_reg + (BLK_AW + 1)'(1);
                    end
                end
            end
            ST_SCAN_V: begin
                if (val_found) begin
                    mexv_next = vchk_reg;
                end else if (val_done) begin
                    mexv_next = VB_W'(VALUE_COUNT);
                end else begin
                    vchk_next  = vi_reg;
                    vpend_next = 1'b1;
                    vi_next    = vi_reg + VB_W'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_mex_next   = MEX_W'(mexv_reg);
                    m_pres_next  = enter_reg;
                end
            end
            default: begin
                clr_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            bpend_reg   <= 1'b0;
            vpend_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            bpend_reg   <= bpend_next;
            vpend_reg   <= vpend_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg   <= node_next;
        value_reg  <= value_next;
        enter_reg  <= enter_next;
        v_reg      <= v_next;
        bump_reg   <= bump_next;
        drop_reg   <= drop_next;
        prod_reg   <= prod_next;
        blkidx_reg <= blkidx_next;
        bi_reg     <= bi_next;
        bchk_reg   <= bchk_next;
        vbase_reg  <= vbase_next;
        vi_reg     <= vi_next;
        vend_reg   <= vend_next;
        vchk_reg   <= vchk_next;
        mexv_reg   <= mexv_next;
        m_mex_reg  <= m_mex_next;
        m_pres_reg <= m_pres_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_mex         = m_mex_reg;
    assign m_now_present = m_pres_reg;

endmodule

`default_nettype wire
